// ===== src/plsm_pkg.sv =====
// ----------------------------------------------------------------------------
// plsm_pkg
// Breakpoint tables and per-segment constants for the piecewise-linear
// sensor map: abscissae, ordinates, slopes and exact reciprocals.
// ----------------------------------------------------------------------------
package plsm_pkg;

  // number of breakpoints and segments
  localparam int unsigned TABLE_POINTS = 10;
  localparam int unsigned SEG_COUNT    = TABLE_POINTS - 1;
  localparam int unsigned SEG_W        = 4;

  // field widths
  localparam int unsigned X_W   = 10;
  localparam int unsigned Y_W   = 10;
  localparam int unsigned OUT_W = 10;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // offset inside a segment is at most the widest segment span (200)
  localparam int unsigned T_W  = 8;
  // largest ordinate step (372)
  localparam int unsigned DY_W = 9;
  // offset times step
  localparam int unsigned P_W  = T_W + DY_W;
  // reciprocal of the span, scaled by 2**RECIP_SHIFT and rounded up;
  // exact floor for every product below 2**P_W at spans up to 256
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned RECIP_SHIFT = 25;
  localparam int unsigned PROD_W      = P_W + RECIP_W;
  // quotient never exceeds the largest step
  localparam int unsigned Q_W = 10;

  localparam logic [OUT_W-1:0] CLAMP_HIGH = OUT_W'(999);

  typedef logic [X_W-1:0]     x_t;
  typedef logic [Y_W-1:0]     y_t;
  typedef logic [DY_W-1:0]    dy_t;
  typedef logic [RECIP_W-1:0] recip_t;

  // breakpoint abscissae
  localparam x_t BP_X [TABLE_POINTS] = '{
    x_t'(200), x_t'(400), x_t'(500), x_t'(600), x_t'(700),
    x_t'(750), x_t'(800), x_t'(850), x_t'(900), x_t'(950)
  };

  // segment tables, indexed by the lower breakpoint of the segment
  localparam y_t SEG_Y0 [SEG_COUNT] = '{
    y_t'(2), y_t'(9), y_t'(16), y_t'(28), y_t'(52),
    y_t'(73), y_t'(106), y_t'(166), y_t'(293)
  };

  localparam dy_t SEG_DY [SEG_COUNT] = '{
    dy_t'(7), dy_t'(7), dy_t'(12), dy_t'(24), dy_t'(21),
    dy_t'(33), dy_t'(60), dy_t'(127), dy_t'(372)
  };

  // ceil(2**25 / span) for spans 200, 100, 100, 100, 50, 50, 50, 50, 50
  localparam recip_t SEG_RECIP [SEG_COUNT] = '{
    recip_t'(167773), recip_t'(335545), recip_t'(335545), recip_t'(335545),
    recip_t'(671089), recip_t'(671089), recip_t'(671089), recip_t'(671089),
    recip_t'(671089)
  };

  // where the sample lies relative to the table
  typedef enum logic [1:0] {
    REG_INSIDE,
    REG_LOW,
    REG_HIGH
  } region_e;

endpackage

// ===== src/piecewise_linear_sensor_map_core.sv =====
// Accepted inputs pass registered stages a, b, c and d to e (m_axis_tvalid_o).
// Throughput: one sample per cycle, set by the five-stage pipeline with a
// per-stage ready chain; a stalled output holds only the stages behind it.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; the
// pipeline is empty and ready once reset is released.
// ----------------------------------------------------------------------------
// piecewise_linear_sensor_map_core
// Maps a converter sample to a reading in thousandths by linear
// interpolation over a fixed breakpoint table, clamped at both ends.
// ----------------------------------------------------------------------------
module piecewise_linear_sensor_map_core
  import plsm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample: [SAMPLE_BITS-1:0] sample, rest zero
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata_i,
  // result: [9:0] reading_thou, rest zero
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]                m_axis_tdata_o
);

  localparam int unsigned CMP_W = (SAMPLE_BITS > X_W) ? SAMPLE_BITS : X_W;

  // stage ready chain
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  // stage a: sample and breakpoint compares
  logic                    a_valid_q;
  logic [CMP_W-1:0]        a_sample_q;
  logic [TABLE_POINTS-1:0] a_le_q;
  logic                    a_hi_q;
  logic [TABLE_POINTS-1:0] a_le_d;
  logic [CMP_W-1:0]        a_sample_d;

  // stage b: segment select, offset and constants
  logic             b_valid_q;
  region_e          b_region_q, b_region_d;
  logic [T_W-1:0]   b_t_q, b_t_d;
  dy_t              b_dy_q;
  recip_t           b_recip_q;
  y_t               b_y0_q;
  logic [SEG_W-1:0] seg_idx;
  logic [CMP_W-1:0] seg_diff;

  // stage c: offset times step
  logic           c_valid_q;
  region_e        c_region_q;
  logic [P_W-1:0] c_p_q;
  recip_t         c_recip_q;
  y_t             c_y0_q;

  // stage d: quotient by reciprocal multiply
  logic              d_valid_q;
  region_e           d_region_q;
  logic [Q_W-1:0]    d_q_q;
  y_t                d_y0_q;
  logic [PROD_W-1:0] d_prod;

  // stage e: output register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_reading_q, out_reading_d;
  logic [OUT_W:0]   out_sum;

  assign rdy_e = !out_valid_q || m_axis_tready_i;
  assign rdy_d = !d_valid_q || rdy_e;
  assign rdy_c = !c_valid_q || rdy_d;
  assign rdy_b = !b_valid_q || rdy_c;
  assign rdy_a = !a_valid_q || rdy_b;

  assign s_axis_tready_o = rdy_a;

  // compare the incoming sample against every breakpoint
  always_comb begin
    a_sample_d = CMP_W'(s_axis_tdata_i[SAMPLE_BITS-1:0]);
    for (int k = 0; k < TABLE_POINTS; k++) begin
      a_le_d[k] = a_sample_d <= CMP_W'(BP_X[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (rdy_a) begin
      a_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && s_axis_tvalid_i) begin
      a_sample_q <= a_sample_d;
      a_le_q     <= a_le_d;
      a_hi_q     <= a_sample_d >= CMP_W'(BP_X[TABLE_POINTS-1]);
    end
  end

  // lowest breakpoint not below the sample closes the segment
  always_comb begin
    seg_idx = SEG_W'(SEG_COUNT - 1);
    for (int k = TABLE_POINTS - 1; k >= 1; k--) begin
      if (a_le_q[k]) begin
        seg_idx = SEG_W'(k - 1);
      end
    end
    seg_diff = a_sample_q - CMP_W'(BP_X[seg_idx]);
    b_t_d    = seg_diff[T_W-1:0];
    priority if (a_le_q[0]) begin
      b_region_d = REG_LOW;
    end else if (a_hi_q) begin
      b_region_d = REG_HIGH;
    end else begin
      b_region_d = REG_INSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (rdy_b) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && a_valid_q) begin
      b_region_q <= b_region_d;
      b_t_q      <= b_t_d;
      b_dy_q     <= SEG_DY[seg_idx];
      b_recip_q  <= SEG_RECIP[seg_idx];
      b_y0_q     <= SEG_Y0[seg_idx];
    end
  end

  // offset times ordinate step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (rdy_c) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && b_valid_q) begin
      c_region_q <= b_region_q;
      c_p_q      <= P_W'(b_t_q) * P_W'(b_dy_q);
      c_recip_q  <= b_recip_q;
      c_y0_q     <= b_y0_q;
    end
  end

  // truncated division by the span via the scaled reciprocal
  assign d_prod = PROD_W'(c_p_q) * PROD_W'(c_recip_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (rdy_d) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && c_valid_q) begin
      d_region_q <= c_region_q;
      d_q_q      <= d_prod[RECIP_SHIFT +: Q_W];
      d_y0_q     <= c_y0_q;
    end
  end

  // add the segment base, clamp, and pick the saturated cases
  always_comb begin
    out_sum = (OUT_W + 1)'(d_y0_q) + (OUT_W + 1)'(d_q_q);
    case (d_region_q)
      REG_LOW:  out_reading_d = '0;
      REG_HIGH: out_reading_d = CLAMP_HIGH;
      REG_INSIDE: begin
        if (out_sum > (OUT_W + 1)'(CLAMP_HIGH)) begin
          out_reading_d = CLAMP_HIGH;
        end else begin
          out_reading_d = out_sum[OUT_W-1:0];
        end
      end
      default:  out_reading_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy_e) begin
      out_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && d_valid_q) begin
      out_reading_q <= out_reading_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_reading_q);

endmodule

// ===== src/plsm_checker.sv =====
// ----------------------------------------------------------------------------
// plsm_checker
// Port-level checks for the sensor map core: result range, occupancy
// bookkeeping, input ready with an empty output, and stalled-result hold.
// ----------------------------------------------------------------------------
module plsm_checker
  import plsm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid_i,
  input logic                                  s_axis_tready_o,
  input logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata_i,
  input logic                                  m_axis_tvalid_o,
  input logic                                  m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0]                m_axis_tdata_o
);

  localparam int unsigned DEPTH = 5;

  logic       in_xfer, out_xfer;
  logic [2:0] inflight_q, inflight_d;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // transactions in flight inside the core
  always_comb begin
    inflight_d = inflight_q;
    if (in_xfer && !out_xfer) begin
      inflight_d = inflight_q + 3'd1;
    end else if (!in_xfer && out_xfer) begin
      inflight_d = inflight_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // readings stay within the table range and padding stays zero
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o <= OUT_TDATA_W'(CLAMP_HIGH)))
    else $error("reading above clamp value");

  // a result is only shown for a sample that went in
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (inflight_q != 3'd0))
    else $error("result without an outstanding sample");

  // no more samples held than pipeline stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'(DEPTH))
    else $error("more samples in flight than stages");

  // an empty output stage never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output empty");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind piecewise_linear_sensor_map_core plsm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_plsm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
